@@ rtl/fexp_pkg.sv @@
// Shared constants, lane record types and pipeline latency for the
// four-lane fixed-point exponential unit. No dependencies.
`default_nettype none

package fexp_pkg;

   localparam int LANES         = 4;
   localparam int ARG_FRAC_BITS = 24;

   localparam int Q_FRAC     = 30;
   localparam int MANT_BITS  = 23;
   localparam int EXP_BIAS   = 127;
   localparam int EXP_OFFSET = EXP_BIAS - Q_FRAC;
   localparam int POLY_STEPS = 4;

   // scaled argument, integer part and exponent widths
   localparam int T_W  = 33;
   localparam int N_W  = T_W + 1 - ARG_FRAC_BITS;
   localparam int E_W  = ((N_W > 9) ? N_W : 9) + 2;

   // split 1 + horner 2*steps + pack 3 + scale 1
   localparam int LATENCY = 1 + 1 + 2 * POLY_STEPS + 3;

   localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
   localparam logic signed [63:0] HALF_Q30  = 64'sd536870912;
   localparam logic [31:0]        INF_BITS  = 32'h7F80_0000;

   localparam logic signed [31:0] POLY_COEF [POLY_STEPS+1] = '{
      32'sd14678383, 32'sd55560768, 32'sd259420703, 32'sd744074009, 32'sd1073745574
   };

   typedef struct packed {
      logic                  vld;
      logic signed [N_W-1:0] n;
      logic signed [31:0]    u;
   } frac_type;

   typedef struct packed {
      logic                  vld;
      logic signed [N_W-1:0] n;
      logic signed [31:0]    d;
   } poly_type;

endpackage

`default_nettype wire

@@ rtl/fast_exp_polynomial_four_lane_unit.sv @@
// Top level of the four-lane exponential unit: per-lane split, Horner and
// pack pipelines. Depends on fexp_pkg, fexp_split, fexp_horner, fexp_pack.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start, busy          | req_mode, req_x_lane0..3 (Q8.24 signed)
//  response  | rsp_valid (strobe)   | rsp_y_lane0..3 (float bits), rsp_range_flags
//
//  A transfer on the request side completes when start is high and busy is low.
//  One item can enter every cycle while busy is low; its result strobes after it has
//  passed the thirteen register stages (scale, split, four multiply/add pairs, normalize,
//  round, saturate). Synchronous reset clears all valid bits; busy is high only
//  during reset. The receiver cannot stall, so nothing is held back.
`default_nettype none

module fast_exp_polynomial_four_lane_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic signed [31:0] req_x_lane0,
   input  wire logic signed [31:0] req_x_lane1,
   input  wire logic signed [31:0] req_x_lane2,
   input  wire logic signed [31:0] req_x_lane3,
   output logic                    rsp_valid,
   output logic [31:0]             rsp_y_lane0,
   output logic [31:0]             rsp_y_lane1,
   output logic [31:0]             rsp_y_lane2,
   output logic [31:0]             rsp_y_lane3,
   output logic [3:0]              rsp_range_flags
);
   import fexp_pkg::*;

   logic               in_vld;
   logic signed [31:0] x      [LANES];
   frac_type           frac   [LANES];
   poly_type           poly   [LANES];
   logic [LANES-1:0]   lane_vld;
   logic [31:0]        y      [LANES];
   logic [LANES-1:0]   flags;

   assign busy   = reset;
   assign in_vld = start && !busy;

   assign x[0] = req_x_lane0;
   assign x[1] = req_x_lane1;
   assign x[2] = req_x_lane2;
   assign x[3] = req_x_lane3;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      fexp_split u_split (
         .clock (clock),
         .reset (reset),
         .vld   (in_vld),
         .mode  (req_mode),
         .x     (x[i]),
         .frac  (frac[i])
      );

      fexp_horner u_horner (
         .clock (clock),
         .reset (reset),
         .frac  (frac[i]),
         .poly  (poly[i])
      );

      fexp_pack u_pack (
         .clock (clock),
         .reset (reset),
         .poly  (poly[i]),
         .vld   (lane_vld[i]),
         .y     (y[i]),
         .flag  (flags[i])
      );
   end

   assign rsp_valid       = &lane_vld;
   assign rsp_y_lane0     = y[0];
   assign rsp_y_lane1     = y[1];
   assign rsp_y_lane2     = y[2];
   assign rsp_y_lane3     = y[3];
   assign rsp_range_flags = flags;

endmodule

`default_nettype wire

@@ rtl/fexp_split.sv @@
// Argument scaling by log2(e) when mode is high, then split into integer part
// and Q2.30 fraction. Two register stages per lane. Depends on fexp_pkg.
`default_nettype none

module fexp_split (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               vld,
   input  wire logic               mode,
   input  wire logic signed [31:0] x,
   output fexp_pkg::frac_type      frac
);
   import fexp_pkg::*;

   logic                  t_vld_ff, t_vld_in;
   logic signed [T_W-1:0] t_ff, t_in;
   logic signed [63:0]    prod;
   logic signed [63:0]    rnd;

   logic                          neg_adj;
   logic [ARG_FRAC_BITS-1:0]      frac_bits;
   logic signed [T_W-ARG_FRAC_BITS-1:0] n_floor;
   frac_type                      frac_ff, frac_in;

   // scale stage
   always_comb begin
      prod     = 64'(x) * 64'(LOG2E_Q30);
      rnd      = prod + HALF_Q30;
      t_vld_in = vld;
      if (mode) begin
         t_in = rnd[Q_FRAC+T_W-1:Q_FRAC];
      end else begin
         t_in = T_W'(x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else begin
         t_vld_ff <= t_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
   end

   // split stage: truncate toward zero
   always_comb begin
      n_floor     = t_ff[T_W-1:ARG_FRAC_BITS];
      frac_bits   = t_ff[ARG_FRAC_BITS-1:0];
      neg_adj     = t_ff[T_W-1] && (frac_bits != '0);
      frac_in.vld = t_vld_ff;
      frac_in.n   = N_W'(n_floor) + N_W'({1'b0, neg_adj});
      frac_in.u   = 32'($signed({neg_adj, frac_bits})) <<< (Q_FRAC - ARG_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff.vld <= 1'b0;
      end else begin
         frac_ff.vld <= frac_in.vld;
      end
      frac_ff.n <= frac_in.n;
      frac_ff.u <= frac_in.u;
   end

   assign frac = frac_ff;

endmodule

`default_nettype wire

@@ rtl/fexp_horner.sv @@
// Degree-4 Horner evaluation of 2^u in Q2.30, one multiply stage and one
// round-and-add stage per Horner step. Depends on fexp_pkg.
`default_nettype none

module fexp_horner (
   input  wire logic         clock,
   input  wire logic         reset,
   input  fexp_pkg::frac_type frac,
   output fexp_pkg::poly_type poly
);
   import fexp_pkg::*;

   logic                  m_vld_ff  [POLY_STEPS];
   logic signed [N_W-1:0] m_n_ff    [POLY_STEPS];
   logic signed [31:0]    m_u_ff    [POLY_STEPS];
   logic signed [63:0]    m_prod_ff [POLY_STEPS];

   logic                  a_vld_ff [POLY_STEPS];
   logic signed [N_W-1:0] a_n_ff   [POLY_STEPS];
   logic signed [31:0]    a_u_ff   [POLY_STEPS-1];
   logic signed [31:0]    a_d_ff   [POLY_STEPS];

   for (genvar k = 0; k < POLY_STEPS; k++) begin : g_step
      logic                  vld_src;
      logic signed [N_W-1:0] n_src;
      logic signed [31:0]    u_src;
      logic signed [31:0]    d_src;
      logic signed [63:0]    prod_in;
      logic signed [63:0]    rnd;
      logic signed [31:0]    d_in;

      if (k == 0) begin : g_first
         assign vld_src = frac.vld;
         assign n_src   = frac.n;
         assign u_src   = frac.u;
         assign d_src   = POLY_COEF[0];
      end else begin : g_next
         assign vld_src = a_vld_ff[k-1];
         assign n_src   = a_n_ff[k-1];
         assign u_src   = a_u_ff[k-1];
         assign d_src   = a_d_ff[k-1];
      end

      assign prod_in = 64'(d_src) * 64'(u_src);
      assign rnd     = m_prod_ff[k] + HALF_Q30;
      assign d_in    = rnd[Q_FRAC+31:Q_FRAC] + POLY_COEF[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            m_vld_ff[k] <= 1'b0;
            a_vld_ff[k] <= 1'b0;
         end else begin
            m_vld_ff[k] <= vld_src;
            a_vld_ff[k] <= m_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         m_n_ff[k]    <= n_src;
         m_u_ff[k]    <= u_src;
         m_prod_ff[k] <= prod_in;
         a_n_ff[k]    <= m_n_ff[k];
         a_d_ff[k]    <= d_in;
      end

      if (k < POLY_STEPS - 1) begin : g_carry_u
         always_ff @(posedge clock) begin
            a_u_ff[k] <= m_u_ff[k];
         end
      end
   end

   assign poly.vld = a_vld_ff[POLY_STEPS-1];
   assign poly.n   = a_n_ff[POLY_STEPS-1];
   assign poly.d   = a_d_ff[POLY_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/fexp_pack.sv @@
// Normalization, mantissa rounding, exponent assembly and saturation into an
// IEEE single bit pattern. Three register stages. Depends on fexp_pkg.
`default_nettype none

module fexp_pack (
   input  wire logic          clock,
   input  wire logic          reset,
   input  fexp_pkg::poly_type poly,
   output logic               vld,
   output logic [31:0]        y,
   output logic               flag
);
   import fexp_pkg::*;

   localparam logic signed [E_W-1:0] E_HIGH = E_W'(255);
   localparam logic signed [E_W-1:0] E_LOW  = E_W'(0);

   // stage 1: leading one
   logic                  l_vld_ff;
   logic signed [N_W-1:0] l_n_ff;
   logic [30:0]           l_d_ff, l_d_in;
   logic [4:0]            l_p_ff, l_p_in;

   // stage 2: round and exponent
   logic                  r_vld_ff;
   logic [MANT_BITS-1:0]  r_m_ff, r_m_in;
   logic signed [E_W-1:0] r_e_ff, r_e_in;
   logic [4:0]            sh;
   logic [31:0]           rnd;
   logic [MANT_BITS+1:0]  m_full;
   logic                  carry;

   // stage 3: saturate
   logic                  o_vld_ff;
   logic [31:0]           o_y_ff, o_y_in;
   logic                  o_flag_ff, o_flag_in;

   always_comb begin
      if (poly.d < 32'sd1) begin
         l_d_in = 31'd1;
      end else begin
         l_d_in = poly.d[30:0];
      end
      l_p_in = '0;
      for (int i = 0; i < 31; i++) begin
         if (l_d_in[i]) begin
            l_p_in = 5'(i);
         end
      end
   end

   always_comb begin
      sh     = '0;
      m_full = '0;
      carry  = 1'b0;
      if (l_p_ff > 5'(MANT_BITS)) begin
         sh     = l_p_ff - 5'(MANT_BITS);
         rnd    = {1'b0, l_d_ff} + (32'd1 << (sh - 5'd1));
         m_full = (MANT_BITS+2)'(rnd >> sh);
         carry  = m_full[MANT_BITS+1];
         if (carry) begin
            m_full = m_full >> 1;
         end
      end else begin
         rnd    = {1'b0, l_d_ff} << (5'(MANT_BITS) - l_p_ff);
         m_full = rnd[MANT_BITS+1:0];
      end
      r_m_in = m_full[MANT_BITS-1:0];
      r_e_in = E_W'(l_n_ff) + E_W'(l_p_ff) + E_W'(carry) + E_W'(EXP_OFFSET);
   end

   always_comb begin
      if (r_e_ff >= E_HIGH) begin
         o_y_in    = INF_BITS;
         o_flag_in = 1'b1;
      end else if (r_e_ff <= E_LOW) begin
         o_y_in    = '0;
         o_flag_in = 1'b1;
      end else begin
         o_y_in    = {1'b0, r_e_ff[7:0], r_m_ff};
         o_flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         l_vld_ff <= poly.vld;
         r_vld_ff <= l_vld_ff;
         o_vld_ff <= r_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      l_n_ff    <= poly.n;
      l_d_ff    <= l_d_in;
      l_p_ff    <= l_p_in;
      r_m_ff    <= r_m_in;
      r_e_ff    <= r_e_in;
      o_y_ff    <= o_y_in;
      o_flag_ff <= o_flag_in;
   end

   assign vld  = o_vld_ff;
   assign y    = o_y_ff;
   assign flag = o_flag_ff;

endmodule

`default_nettype wire

@@ rtl/fexp_check.sv @@
// Port-level checks for the exponential unit and the bind that attaches them.
// Depends on fexp_pkg and fast_exp_polynomial_four_lane_unit.
`default_nettype none

module fexp_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_y_lane0,
   input wire logic [31:0] rsp_y_lane1,
   input wire logic [31:0] rsp_y_lane2,
   input wire logic [31:0] rsp_y_lane3,
   input wire logic [3:0]  rsp_range_flags
);
   import fexp_pkg::*;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transfer produced no result strobe");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching request transfer");

   a_flags_match : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_range_flags[0] == (rsp_y_lane0 == 32'd0 || rsp_y_lane0 == INF_BITS)) &&
         (rsp_range_flags[1] == (rsp_y_lane1 == 32'd0 || rsp_y_lane1 == INF_BITS)) &&
         (rsp_range_flags[2] == (rsp_y_lane2 == 32'd0 || rsp_y_lane2 == INF_BITS)) &&
         (rsp_range_flags[3] == (rsp_y_lane3 == 32'd0 || rsp_y_lane3 == INF_BITS)))
      else $error("range flag disagrees with saturated result");

   a_positive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_y_lane0[31] && !rsp_y_lane1[31] &&
                    !rsp_y_lane2[31] && !rsp_y_lane3[31])
      else $error("negative result sign");

endmodule

bind fast_exp_polynomial_four_lane_unit fexp_check u_fexp_check (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_y_lane0     (rsp_y_lane0),
   .rsp_y_lane1     (rsp_y_lane1),
   .rsp_y_lane2     (rsp_y_lane2),
   .rsp_y_lane3     (rsp_y_lane3),
   .rsp_range_flags (rsp_range_flags)
);

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the four-lane fixed-point exponential unit.
// Directed table then random traffic, checked against known table results or a
// bit-exact predictor. Depends on fexp_pkg, fast_exp_polynomial_four_lane_unit.
`timescale 1ns / 100ps

module testbench;

   localparam logic MODE_BASE2  = 1'b0;
   localparam logic MODE_BASE_E = 1'b1;

   localparam int          NUM_LANES  = fexp_pkg::LANES;
   localparam int          FRAC_IN    = 24;
   localparam int          FRAC_POLY  = 30;
   localparam int          MANT_W     = 23;
   localparam int          BIAS       = 127;
   localparam longint      LOG2E_FIX  = 64'sd1549082005;
   localparam longint      HALF_FIX   = 64'sd536870912;
   localparam logic [31:0] FLOAT_INF  = 32'h7F80_0000;
   localparam logic [31:0] FLOAT_ZERO = 32'h0000_0000;
   localparam logic [31:0] FLOAT_ONE  = 32'h3F80_001D;

   localparam longint HORNER_COEF [5] = '{
      64'sd14678383, 64'sd55560768, 64'sd259420703, 64'sd744074009, 64'sd1073745574
   };

   typedef struct packed {
      logic             mode;
      logic [3:0][31:0] x;
   } exp_req_t;

   typedef struct packed {
      logic [3:0][31:0] y;
      logic [3:0]       flags;
   } exp_rsp_t;

   typedef struct {
      exp_req_t req;
      bit       known;
      exp_rsp_t rsp;
   } dir_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_mode = MODE_BASE2;
   logic signed [31:0]  req_x_lane0 = '0;
   logic signed [31:0]  req_x_lane1 = '0;
   logic signed [31:0]  req_x_lane2 = '0;
   logic signed [31:0]  req_x_lane3 = '0;
   logic                rsp_valid;
   logic [31:0]         rsp_y_lane0;
   logic [31:0]         rsp_y_lane1;
   logic [31:0]         rsp_y_lane2;
   logic [31:0]         rsp_y_lane3;
   logic [3:0]          rsp_range_flags;

   exp_rsp_t pending_exps [$];
   dir_row_t directed_rows [$];
   int       mismatch_count  = 0;
   int       results_seen    = 0;
   int       saturated_lanes = 0;
   int       directed_sent   = 0;
   int       random_sent     = 0;

   fast_exp_polynomial_four_lane_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_x_lane0     (req_x_lane0),
      .req_x_lane1     (req_x_lane1),
      .req_x_lane2     (req_x_lane2),
      .req_x_lane3     (req_x_lane3),
      .rsp_valid       (rsp_valid),
      .rsp_y_lane0     (rsp_y_lane0),
      .rsp_y_lane1     (rsp_y_lane1),
      .rsp_y_lane2     (rsp_y_lane2),
      .rsp_y_lane3     (rsp_y_lane3),
      .rsp_range_flags (rsp_range_flags)
   );

   always #10 clock = ~clock;

   initial begin
      #(4_000_000);
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [31:0] exp_lane_bits(input logic signed [31:0] arg,
                                                 input bit base_e, output bit sat);
      longint      t, n, u, d, e;
      logic [63:0] m;
      int          p, sh, i;
      t = longint'(arg);
      if (base_e)
         t = (longint'(arg) * LOG2E_FIX + HALF_FIX) >>> FRAC_POLY;
      n = t / (64'sd1 <<< FRAC_IN);
      u = (t - n * (64'sd1 <<< FRAC_IN)) * (64'sd1 <<< (FRAC_POLY - FRAC_IN));
      d = HORNER_COEF[0];
      for (i = 1; i < 5; i++)
         d = ((d * u + HALF_FIX) >>> FRAC_POLY) + HORNER_COEF[i];
      if (d < 1)
         d = 1;
      p = 0;
      while (p < 62 && (d >>> (p + 1)) != 0)
         p++;
      if (p > MANT_W) begin
         sh = p - MANT_W;
         m = ($unsigned(d) + (64'd1 << (sh - 1))) >> sh;
         if ((m >> (MANT_W + 1)) != 0) begin
            m = m >> 1;
            p++;
         end
      end else begin
         m = $unsigned(d) << (MANT_W - p);
      end
      e = n + p - FRAC_POLY + BIAS;
      sat = 1'b1;
      if (e >= 255)
         return FLOAT_INF;
      if (e <= 0)
         return FLOAT_ZERO;
      sat = 1'b0;
      return {1'b0, e[7:0], m[22:0]};
   endfunction

   function automatic exp_rsp_t predict_exp(input exp_req_t r);
      exp_rsp_t res;
      bit       sat;
      res = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         res.y[i] = exp_lane_bits(r.x[i], r.mode == MODE_BASE_E, sat);
         res.flags[i] = sat;
      end
      return res;
   endfunction

   function automatic logic [31:0] random_arg();
      logic [31:0] corner [5];
      corner = '{32'h7F00_0000, 32'h8100_0000, 32'h8200_0000, 32'h58B9_0000, 32'hA8AC_0000};
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom();
         5, 6, 7:       return $urandom_range(32'd2952790016, 0) - 32'd1476395008;
         8:             return $urandom_range(32'h0200_0000, 0) - 32'h0100_0000;
         default:       return corner[$urandom_range(4)] + $urandom_range(32'h3_FFFF, 0)
                                  - 32'h2_0000;
      endcase
   endfunction

   function automatic exp_req_t random_request();
      exp_req_t r;
      r.mode = $urandom_range(1) ? MODE_BASE_E : MODE_BASE2;
      for (int i = 0; i < NUM_LANES; i++)
         r.x[i] = random_arg();
      return r;
   endfunction

   task automatic add_row(input logic mode, input logic [31:0] a, b, c, d,
                          input bit known = 1'b0,
                          input logic [31:0] y0 = '0, y1 = '0, y2 = '0, y3 = '0,
                          input logic [3:0] flags = '0);
      dir_row_t row;
      row.req.mode = mode;
      row.req.x = {d, c, b, a};
      row.known = known;
      row.rsp.y = {y3, y2, y1, y0};
      row.rsp.flags = flags;
      directed_rows.push_back(row);
   endtask

   task automatic send_item(input exp_req_t r, input exp_rsp_t want);
      start <= 1'b1;
      req_mode <= r.mode;
      req_x_lane0 <= r.x[0];
      req_x_lane1 <= r.x[1];
      req_x_lane2 <= r.x[2];
      req_x_lane3 <= r.x[3];
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      pending_exps.push_back(want);
   endtask

   task automatic idle_cycle();
      start <= 1'b0;
      req_mode <= $urandom_range(1) ? MODE_BASE_E : MODE_BASE2;
      req_x_lane0 <= $urandom();
      req_x_lane1 <= $urandom();
      req_x_lane2 <= $urandom();
      req_x_lane3 <= $urandom();
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_exps.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int idle_pct);
      exp_req_t r;
      for (int i = 0; i < count; i++) begin
         while ($urandom_range(99) < idle_pct)
            idle_cycle();
         r = random_request();
         send_item(r, predict_exp(r));
         random_sent++;
      end
      drain();
   endtask

   always @(posedge clock) begin
      exp_rsp_t want;
      exp_rsp_t got;
      if (reset == 1'b0 && rsp_valid === 1'b1) begin
         got.y = {rsp_y_lane3, rsp_y_lane2, rsp_y_lane1, rsp_y_lane0};
         got.flags = rsp_range_flags;
         results_seen++;
         if (pending_exps.size() == 0) begin
            $error("result transfer with nothing expected: flags %h", got.flags);
            mismatch_count++;
         end else begin
            want = pending_exps.pop_front();
            for (int i = 0; i < NUM_LANES; i++) begin
               if (got.y[i] !== want.y[i]) begin
                  $error("rsp_y_lane%0d: expected %h, got %h", i, want.y[i], got.y[i]);
                  mismatch_count++;
               end
               if (want.flags[i])
                  saturated_lanes++;
            end
            if (got.flags !== want.flags) begin
               $error("rsp_range_flags: expected %h, got %h", want.flags, got.flags);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      exp_rsp_t want;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_row(MODE_BASE2, 32'h0000_0000, 32'h0100_0000, 32'hFF00_0000, 32'h7F00_0000, 1'b1,
              FLOAT_ONE, 32'h4000_001D, 32'h3F00_001D, 32'h7F00_001D, 4'b0000);
      add_row(MODE_BASE2, 32'h8200_0000, 32'h8100_0000, 32'h8000_0000, 32'h0000_0000, 1'b1,
              32'h0080_001D, FLOAT_ZERO, FLOAT_ZERO, FLOAT_ONE, 4'b0110);
      add_row(MODE_BASE_E, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1,
              FLOAT_INF, FLOAT_ZERO, FLOAT_ONE, FLOAT_ZERO, 4'b1011);
      add_row(MODE_BASE_E, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
              FLOAT_ONE, FLOAT_ONE, FLOAT_ONE, FLOAT_ONE, 4'b0000);
      add_row(MODE_BASE2, 32'h8000_0000, 32'h7F00_0000, 32'h0000_0000, 32'h8100_0000, 1'b1,
              FLOAT_ZERO, 32'h7F00_001D, FLOAT_ONE, FLOAT_ZERO, 4'b1001);
      add_row(MODE_BASE2, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0080_0000, 32'hFF80_0000);
      add_row(MODE_BASE_E, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0080_0000, 32'hFF80_0000);
      add_row(MODE_BASE2, 32'h7FFF_FFFF, 32'h8180_0000, 32'h7F80_0000, 32'h8080_0000);
      add_row(MODE_BASE_E, 32'h58B9_0000, 32'h58B0_0000, 32'hA8A0_0000, 32'hA8B0_0000);
      add_row(MODE_BASE_E, 32'h0100_0000, 32'hFF00_0000, 32'h7F00_0000, 32'h8100_0000);
      add_row(MODE_BASE2, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FF00, 32'h00FF_FFFF);
      add_row(MODE_BASE_E, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FF00, 32'h00FF_FFFF);
      add_row(MODE_BASE2, 32'h8000_0001, 32'h80FF_FFFF, 32'h7EFF_FFFF, 32'hFE80_0000);

      foreach (directed_rows[k]) begin
         want = directed_rows[k].known ? directed_rows[k].rsp : predict_exp(directed_rows[k].req);
         send_item(directed_rows[k].req, want);
         directed_sent++;
      end
      drain();

      run_phase(250, 0);
      run_phase(200, 64);
      run_phase(200, 18);
      run_phase(200, 0);

      repeat (fexp_pkg::LATENCY + 4) @(posedge clock);
      if (pending_exps.size() != 0) begin
         $error("%0d expected results never arrived", pending_exps.size());
         mismatch_count++;
      end

      $display("Sent %0d directed and %0d random transfers in both modes, idle 0/64/18 pct.",
               directed_sent, random_sent);
      $display("Checked %0d results, %0d saturated lanes, %0d mismatches.",
               results_seen, saturated_lanes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
